// ===== hdl/oaid_pkg.sv =====
`default_nettype none
package oaid_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef enum logic [1:0] {
    FN_INSERT    = 2'd0,
    FN_DELETE    = 2'd1,
    FN_DEL_VALUE = 2'd2,
    FN_READ      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY
  } state_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  val;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/oaid_cell.sv =====
`default_nettype none
module oaid_cell (
  input  wire logic                               clk,
  input  wire oaid_pkg::cell_cmd_t                cmd,
  input  wire logic [oaid_pkg::IDX_W-1:0]         cell_idx,
  input  wire logic signed [oaid_pkg::VAL_W-1:0]  left_i,
  input  wire logic signed [oaid_pkg::VAL_W-1:0]  right_i,
  input  wire logic                               cmp_en,
  input  wire logic signed [oaid_pkg::VAL_W-1:0]  cmp_val,
  output logic signed [oaid_pkg::VAL_W-1:0]       entry_o,
  output logic                                    hit_o
);

  logic signed [oaid_pkg::VAL_W-1:0] entry_r, entry_nxt;
  logic                              hit_r;

  // shift up above the insert point, shift down from the delete point
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      oaid_pkg::CMD_INS: begin
        if (cell_idx == cmd.idx) begin
          entry_nxt = cmd.val;
        end else if (cell_idx > cmd.idx) begin
          entry_nxt = left_i;
        end
      end
      oaid_pkg::CMD_DEL: begin
        if (cell_idx >= cmd.idx) begin
          entry_nxt = right_i;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cmp_en) begin
      hit_r <= (entry_r == cmp_val);
    end
  end

  assign entry_o = entry_r;
  assign hit_o   = hit_r;

endmodule
`default_nettype wire

// ===== hdl/ordered_array_insert_delete.sv =====
`default_nettype none
// Ordered array kept in a row of 16 cells, one signed 32-bit entry per cell,
// plus an entry count. Each input transaction is one operation selected by
// in_tuser: insert at a position (later entries move up), delete at a position
// (later entries move down), delete the highest-indexed entry equal to a value,
// or read an entry. Each operation returns exactly one result transaction with
// a status in out_tuser; on any error the array and count are untouched and
// data and index read as zero. An operation has a compare step and an apply step:
// in the accept cycle every cell compares its entry with the incoming value,
// and in the apply step the matches are resolved and all cells shift at once as
// the result is loaded into the output register. The block takes no new
// transaction until the apply step is done; a held result stalls only the
// apply step.
module ordered_array_insert_delete (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [4:0] position, [36:5] value, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] data, [36:32] where, [41:37] count_after
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int DEPTH = oaid_pkg::DEPTH;
  localparam int IDX_W = oaid_pkg::IDX_W;
  localparam int CNT_W = oaid_pkg::CNT_W;
  localparam int VAL_W = oaid_pkg::VAL_W;
  localparam int POS_W = oaid_pkg::POS_W;

  // control state
  oaid_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // captured operation
  oaid_pkg::func_t          func_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [VAL_W-1:0]  val_r;

  // result register
  oaid_pkg::status_t        status_r, status_nxt;
  logic signed [VAL_W-1:0]  data_r, data_nxt;
  logic [POS_W-1:0]         where_r, where_nxt;
  logic [CNT_W-1:0]         cnt_out_r, cnt_out_nxt;

  // cell row
  oaid_pkg::cell_cmd_t      cmd;
  logic signed [VAL_W-1:0]  entry [DEPTH];
  logic [DEPTH-1:0]         hit;
  logic                     in_acc;
  logic                     apply_go;

  // highest matching live entry
  logic                     any_hit;
  logic [IDX_W-1:0]         hit_at;
  logic [IDX_W-1:0]         pos_idx;
  logic [CNT_W-1:0]         pos_ext;

  assign in_acc  = in_tvalid && in_tready;
  assign pos_idx = pos_r[IDX_W-1:0];
  assign pos_ext = CNT_W'(pos_r);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [VAL_W-1:0] left_v, right_v;
      if (gi == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = entry[gi+1];
      end
      oaid_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .cell_idx (IDX_W'(gi)),
        .left_i   (left_v),
        .right_i  (right_v),
        .cmp_en   (in_acc),
        .cmp_val  (in_tdata[36:5]),
        .entry_o  (entry[gi]),
        .hit_o    (hit[gi])
      );
    end
  endgenerate

  // priority pick, only entries below the count count as live
  always_comb begin
    any_hit = 1'b0;
    hit_at  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i] && (CNT_W'(i) < count_r)) begin
        any_hit = 1'b1;
        hit_at  = IDX_W'(i);
      end
    end
  end

  // apply step waits only while a result is still held
  assign apply_go = (state_r == oaid_pkg::S_APPLY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    where_nxt     = where_r;
    cnt_out_nxt   = cnt_out_r;
    cmd.op        = oaid_pkg::CMD_HOLD;
    cmd.idx       = pos_idx;
    cmd.val       = val_r;
    in_tready     = (state_r == oaid_pkg::S_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      oaid_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = oaid_pkg::S_APPLY;
        end
      end
      oaid_pkg::S_APPLY: begin
        if (apply_go) begin
          state_nxt     = oaid_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = oaid_pkg::ST_BADPOS;
          data_nxt      = '0;
          where_nxt     = '0;
          case (func_r)
            oaid_pkg::FN_INSERT: begin
              if (pos_ext > count_r) begin
                status_nxt = oaid_pkg::ST_BADPOS;
              end else if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = oaid_pkg::ST_FULL;
              end else begin
                status_nxt = oaid_pkg::ST_OK;
                data_nxt   = val_r;
                where_nxt  = pos_r;
                count_nxt  = count_r + CNT_W'(1);
                cmd.op     = oaid_pkg::CMD_INS;
              end
            end
            oaid_pkg::FN_DELETE: begin
              if (pos_ext < count_r) begin
                status_nxt = oaid_pkg::ST_OK;
                data_nxt   = entry[pos_idx];
                where_nxt  = pos_r;
                count_nxt  = count_r - CNT_W'(1);
                cmd.op     = oaid_pkg::CMD_DEL;
              end
            end
            oaid_pkg::FN_DEL_VALUE: begin
              if (!any_hit) begin
                status_nxt = oaid_pkg::ST_NOTFOUND;
              end else begin
                status_nxt = oaid_pkg::ST_OK;
                data_nxt   = val_r;
                where_nxt  = POS_W'(hit_at);
                count_nxt  = count_r - CNT_W'(1);
                cmd.op     = oaid_pkg::CMD_DEL;
                cmd.idx    = hit_at;
              end
            end
            oaid_pkg::FN_READ: begin
              if (pos_ext < count_r) begin
                status_nxt = oaid_pkg::ST_OK;
                data_nxt   = entry[pos_idx];
                where_nxt  = pos_r;
              end
            end
            default: status_nxt = oaid_pkg::ST_BADPOS;
          endcase
          cnt_out_nxt = count_nxt;
        end
      end
      default: state_nxt = oaid_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaid_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= oaid_pkg::func_t'(in_tuser);
      pos_r  <= in_tdata[4:0];
      val_r  <= in_tdata[36:5];
    end
    status_r  <= status_nxt;
    data_r    <= data_nxt;
    where_r   <= where_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'd0, POS_W'(cnt_out_r), where_r, data_r};

endmodule
`default_nettype wire

// ===== test/ordered_array_insert_delete_tb.sv =====
`timescale 1ns / 1ps
module ordered_array_insert_delete_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    oaid_pkg::status_t  status;
    logic signed [31:0] data;
    logic [4:0]         where;
    logic [4:0]         count_after;
  } op_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [4:0] position, [36:5] value, rest zero
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] data, [36:32] where, [41:37] count_after
  logic [1:0]  out_tuser;  // [1:0] status

  ordered_array_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // shadow copy of the array and its fill count
  logic signed [31:0] model_entries [oaid_pkg::DEPTH];
  logic [4:0]         model_count;
  op_result_t         expected_results [$];

  bit sender_idling = 1'b1;
  bit sink_idling   = 1'b1;
  bit hold_request  = 1'b0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int func_hits   [4];
  int status_hits [4];
  int peak_fill   = 0;
  int stall_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one operation applied to the shadow array, result queued
  task automatic predict_array_op(input oaid_pkg::func_t fn, input logic [4:0] pos,
                                  input logic signed [31:0] val);
    op_result_t r;
    int         k;
    int         at;
    bit         hit;
    r.status = oaid_pkg::ST_OK;
    r.data   = '0;
    r.where  = '0;
    hit      = 1'b0;
    at       = 0;
    case (fn)
      oaid_pkg::FN_INSERT: begin
        if (pos > model_count) begin
          r.status = oaid_pkg::ST_BADPOS;
        end else if (model_count >= oaid_pkg::DEPTH) begin
          r.status = oaid_pkg::ST_FULL;
        end else begin
          for (k = int'(model_count); k > int'(pos); k--)
            model_entries[k] = model_entries[k-1];
          model_entries[pos] = val;
          model_count++;
          r.data  = val;
          r.where = pos;
        end
      end
      oaid_pkg::FN_DELETE, oaid_pkg::FN_DEL_VALUE: begin
        if (fn == oaid_pkg::FN_DELETE) begin
          hit = (pos < model_count);
          at  = int'(pos);
        end else begin
          // the highest matching index wins
          for (k = 0; k < int'(model_count); k++) begin
            if (model_entries[k] == val) begin
              hit = 1'b1;
              at  = k;
            end
          end
        end
        if (!hit) begin
          r.status = (fn == oaid_pkg::FN_DELETE) ? oaid_pkg::ST_BADPOS
                                                 : oaid_pkg::ST_NOTFOUND;
        end else begin
          r.data  = model_entries[at];
          r.where = at[4:0];
          for (k = at; k + 1 < int'(model_count); k++)
            model_entries[k] = model_entries[k+1];
          model_count--;
        end
      end
      default: begin
        if (pos >= model_count) begin
          r.status = oaid_pkg::ST_BADPOS;
        end else begin
          r.data  = model_entries[pos];
          r.where = pos;
        end
      end
    endcase
    r.count_after = model_count;
    func_hits[fn]++;
    status_hits[r.status]++;
    if (int'(model_count) > peak_fill) peak_fill = int'(model_count);
    expected_results.push_back(r);
  endtask

  // drive one transaction from a falling edge and hold it until accepted
  task automatic send_array_op(input oaid_pkg::func_t fn, input int pos,
                               input logic signed [31:0] val);
    @(negedge clk);
    if (sender_idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {3'b000, val, pos[4:0]};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    predict_array_op(fn, pos[4:0], val);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 8) - 4;  // small pool makes duplicates
    if (r < 40) return VAL_MAX;
    if (r < 45) return VAL_MIN;
    return $urandom;
  endfunction

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 7);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  op_result_t oldest;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: status %0d data %0d",
               out_tuser, $signed(out_tdata[31:0]));
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        results_seen++;
        if (out_tuser !== oldest.status) begin
          $error("status: expected %0d actual %0d", oldest.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[31:0] !== oldest.data) begin
          $error("data: expected %0d actual %0d", oldest.data, $signed(out_tdata[31:0]));
          mismatch_count++;
        end
        if (out_tdata[36:32] !== oldest.where) begin
          $error("where: expected %0d actual %0d", oldest.where, out_tdata[36:32]);
          mismatch_count++;
        end
        if (out_tdata[41:37] !== oldest.count_after) begin
          $error("count_after: expected %0d actual %0d", oldest.count_after,
                 out_tdata[41:37]);
          mismatch_count++;
        end
      end
    end
  end

  // run ends if neither side moves for too long
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // error paths on an empty array, appends, duplicates, extremes
  task automatic test_directed_ops();
    send_array_op(oaid_pkg::FN_READ, 0, 0);
    send_array_op(oaid_pkg::FN_DELETE, 0, 0);
    send_array_op(oaid_pkg::FN_DEL_VALUE, 0, 0);
    send_array_op(oaid_pkg::FN_INSERT, 1, 5);          // past the count
    send_array_op(oaid_pkg::FN_INSERT, 0, VAL_MAX);
    send_array_op(oaid_pkg::FN_INSERT, 1, VAL_MIN);    // append at the count
    send_array_op(oaid_pkg::FN_INSERT, 0, -1);
    send_array_op(oaid_pkg::FN_INSERT, 2, 0);
    send_array_op(oaid_pkg::FN_READ, 3, 0);
    send_array_op(oaid_pkg::FN_READ, 4, 0);
    send_array_op(oaid_pkg::FN_INSERT, 1, 7);
    send_array_op(oaid_pkg::FN_INSERT, 5, 7);
    send_array_op(oaid_pkg::FN_INSERT, 3, 7);
    send_array_op(oaid_pkg::FN_DEL_VALUE, 0, 7);       // last of three copies
    send_array_op(oaid_pkg::FN_DEL_VALUE, 0, 7);
    send_array_op(oaid_pkg::FN_DEL_VALUE, 0, 12345);
    send_array_op(oaid_pkg::FN_DELETE, 0, 0);
    send_array_op(oaid_pkg::FN_DELETE, 4, 0);
    send_array_op(oaid_pkg::FN_DELETE, 3, 0);
    send_array_op(oaid_pkg::FN_READ, 0, 0);
    send_array_op(oaid_pkg::FN_READ, 1, 0);
    send_array_op(oaid_pkg::FN_READ, 2, 0);
    send_array_op(oaid_pkg::FN_INSERT, 16, 1);
  endtask

  // fill to DEPTH, then hit the full and out-of-range cases
  task automatic test_full_array();
    while (model_count < oaid_pkg::DEPTH)
      send_array_op(oaid_pkg::FN_INSERT, $urandom_range(0, model_count), pick_value());
    send_array_op(oaid_pkg::FN_INSERT, 16, 9);
    send_array_op(oaid_pkg::FN_INSERT, 0, 9);
    send_array_op(oaid_pkg::FN_READ, 16, 0);
    send_array_op(oaid_pkg::FN_READ, 15, 0);
    send_array_op(oaid_pkg::FN_DELETE, 16, 0);
    send_array_op(oaid_pkg::FN_DELETE, 15, 0);
    send_array_op(oaid_pkg::FN_DELETE, 0, 0);
    send_array_op(oaid_pkg::FN_INSERT, 15, 3);
    send_array_op(oaid_pkg::FN_INSERT, 14, 3);
  endtask

  // mostly valid operations, fill level drifting between empty and full
  task automatic test_random_ops(input int n_ops);
    int              sel;
    int              pos;
    bit              grow;
    oaid_pkg::func_t fn;
    logic signed [31:0] val;
    grow = 1'b1;
    for (int i = 0; i < n_ops; i++) begin
      if (model_count == oaid_pkg::DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (model_count == 0) grow = 1'b1;
      if ($urandom_range(0, 47) == 0) grow = !grow;
      sel = $urandom_range(0, 99);
      val = pick_value();
      if (sel < 8) begin
        // noise: any func, any position from 0 to 16
        fn  = oaid_pkg::func_t'($urandom_range(0, 3));
        pos = $urandom_range(0, 16);
      end else begin
        sel = $urandom_range(0, 99);
        if (grow) fn = (sel < 55) ? oaid_pkg::FN_INSERT : (sel < 70) ? oaid_pkg::FN_DELETE :
                       (sel < 85) ? oaid_pkg::FN_DEL_VALUE : oaid_pkg::FN_READ;
        else      fn = (sel < 25) ? oaid_pkg::FN_INSERT : (sel < 55) ? oaid_pkg::FN_DELETE :
                       (sel < 80) ? oaid_pkg::FN_DEL_VALUE : oaid_pkg::FN_READ;
        if (fn == oaid_pkg::FN_INSERT) pos = $urandom_range(0, model_count);
        else if (model_count == 0) pos = $urandom_range(0, 16);
        else pos = $urandom_range(0, model_count - 1);
        if (fn == oaid_pkg::FN_DEL_VALUE && model_count > 0 && $urandom_range(0, 9) < 7)
          val = model_entries[$urandom_range(0, model_count - 1)];
      end
      send_array_op(fn, pos, val);
    end
  endtask

  // long hold-off on the result side while items keep coming
  task automatic test_input_backpressure();
    sender_idling = 1'b0;
    hold_request  = 1'b1;
    test_random_ops(40);
    sender_idling = 1'b1;
  endtask

  // closing stretch with both sides always ready
  task automatic test_full_rate();
    sender_idling = 1'b0;
    sink_idling   = 1'b0;
    test_random_ops(150);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    model_count = '0;
    for (int k = 0; k < oaid_pkg::DEPTH; k++) model_entries[k] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_full_array();
    test_random_ops(1430);
    test_input_backpressure();
    test_full_rate();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations: insert %0d, delete %0d, delete by value %0d, read %0d",
             results_seen, func_hits[oaid_pkg::FN_INSERT], func_hits[oaid_pkg::FN_DELETE],
             func_hits[oaid_pkg::FN_DEL_VALUE], func_hits[oaid_pkg::FN_READ]);
    $display("status ok %0d, bad position %0d, full %0d, not found %0d; peak fill %0d",
             status_hits[oaid_pkg::ST_OK], status_hits[oaid_pkg::ST_BADPOS],
             status_hits[oaid_pkg::ST_FULL], status_hits[oaid_pkg::ST_NOTFOUND], peak_fill);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
